>>> sv/i4bqdp_pkg.sv
// Shared types, constants and helper functions for the int4 block-quant dot product.
package i4bqdp_pkg;

  localparam int MAX_K_DEF     = 16384;
  localparam int MAX_BLOCK_DEF = 256;

  localparam int ACT_W   = 16;
  localparam int CODE_W  = 4;
  localparam int SCALE_W = 16;
  localparam int BIAS_W  = 32;
  localparam int SUM_W   = 64;
  localparam int COL_W   = 16;
  localparam int BACC_W  = 30;
  localparam int PROD_W  = BACC_W + SCALE_W;

  localparam int BLEN_W = 9;
  localparam int KCNT_W = 15;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 3;

  localparam int IN_W  = 72;
  localparam int OUT_W = 80;

  localparam logic [CODE_W-1:0] IMPLICIT_ZP = 4'd8;

  typedef enum logic [IDX_W-1:0] {
    REG_BLOCK_LENGTH = 3'd0,
    REG_COUNT_K      = 3'd1,
    REG_COLUMN_COUNT = 3'd2,
    REG_ZP_MODE      = 3'd3,
    REG_BIAS_ENABLE  = 3'd4
  } reg_idx_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;
    logic step;
    logic mult;
    logic accum;
    logic emit;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic blk_end;
    logic col_end;
    logic out_busy;
  } dp_status_t;

  function automatic logic signed [SUM_W-1:0] sat_add64(
    input logic signed [SUM_W-1:0] a,
    input logic signed [SUM_W-1:0] b
  );
    logic signed [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      sat_add64 = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_add64 = s[SUM_W-1:0];
    end
  endfunction

endpackage

>>> sv/i4bqdp_ctrl.sv
// Controller state machine: sequences accept, block MAC, scale multiply, accumulate, emit.
module i4bqdp_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  i4bqdp_pkg::dp_status_t status,
  output i4bqdp_pkg::dp_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MAC   = 5'b00010,
    S_SCALE = 5'b00100,
    S_ACC   = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    in_ready    = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_MAC;
        end
      end
      S_MAC: begin
        cmd.step   = 1'b1;
        state_next = status.blk_end ? S_SCALE : S_IDLE;
      end
      S_SCALE: begin
        cmd.mult   = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.accum  = 1'b1;
        state_next = status.col_end ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        // hold until the output register is free
        if (!status.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> sv/i4bqdp_dp.sv
// Datapath: config registers, counters, block and column accumulators, output register.
module i4bqdp_dp #(
  parameter int MAX_K     = i4bqdp_pkg::MAX_K_DEF,
  parameter int MAX_BLOCK = i4bqdp_pkg::MAX_BLOCK_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [i4bqdp_pkg::IDX_W-1:0]      cfg_index,
  input  logic [i4bqdp_pkg::CFG_W-1:0]      cfg_data,
  input  logic [i4bqdp_pkg::IN_W-1:0]       in_data,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [i4bqdp_pkg::OUT_W-1:0]      out_data,
  output logic                              out_last,
  input  i4bqdp_pkg::dp_cmd_t               cmd,
  output i4bqdp_pkg::dp_status_t            status
);

  localparam int KW   = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int BW   = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int KCMP = ((KW > i4bqdp_pkg::KCNT_W) ? KW : i4bqdp_pkg::KCNT_W) + 2;
  localparam int BCMP = ((BW > i4bqdp_pkg::BLEN_W) ? BW : i4bqdp_pkg::BLEN_W) + 2;

  localparam int SUM_W  = i4bqdp_pkg::SUM_W;
  localparam int BACC_W = i4bqdp_pkg::BACC_W;
  localparam int PROD_W = i4bqdp_pkg::PROD_W;
  localparam int COL_W  = i4bqdp_pkg::COL_W;

  // config
  logic [i4bqdp_pkg::BLEN_W-1:0] block_length;
  logic [i4bqdp_pkg::KCNT_W-1:0] count_k;
  logic [COL_W-1:0]              column_count;
  logic                          zero_point_mode;
  logic                          bias_enable;

  // input word
  logic signed [i4bqdp_pkg::ACT_W-1:0]   act;
  logic [i4bqdp_pkg::CODE_W-1:0]         wcode;
  logic signed [i4bqdp_pkg::SCALE_W-1:0] scale;
  logic [i4bqdp_pkg::CODE_W-1:0]         zpcode;
  logic signed [i4bqdp_pkg::BIAS_W-1:0]  bias;

  // state
  logic signed [BACC_W-1:0] block_acc;
  logic signed [BACC_W-1:0] blk_total;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  col_acc;
  logic [KW-1:0]            pos_col;
  logic [BW-1:0]            pos_blk;
  logic [COL_W-1:0]         col_cnt;
  logic [COL_W-1:0]         col_idx;
  logic                     last_r;
  logic                     col_end_r;
  logic signed [SUM_W-1:0]  out_sum;
  logic [COL_W-1:0]         out_idx;
  logic                     out_last_r;
  logic                     out_valid_r;

  // combinational
  logic [KCMP-1:0]           kc, klen_m1;
  logic [BCMP-1:0]           bc, blen_m1;
  logic [COL_W-1:0]          ncol_m1;
  logic                      col_end, blk_end, last;
  logic [i4bqdp_pkg::CODE_W-1:0] zp;
  logic signed [i4bqdp_pkg::CODE_W:0] diff;
  logic signed [BACC_W-1:0]  mac_sum;
  logic signed [SUM_W-1:0]   bias_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_length    <= i4bqdp_pkg::BLEN_W'(32);
      count_k         <= i4bqdp_pkg::KCNT_W'(4096);
      column_count    <= COL_W'(1);
      zero_point_mode <= 1'b0;
      bias_enable     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        i4bqdp_pkg::REG_BLOCK_LENGTH: block_length    <= cfg_data[i4bqdp_pkg::BLEN_W-1:0];
        i4bqdp_pkg::REG_COUNT_K:      count_k         <= cfg_data[i4bqdp_pkg::KCNT_W-1:0];
        i4bqdp_pkg::REG_COLUMN_COUNT: column_count    <= cfg_data[COL_W-1:0];
        i4bqdp_pkg::REG_ZP_MODE:      zero_point_mode <= cfg_data[0];
        i4bqdp_pkg::REG_BIAS_ENABLE:  bias_enable     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective lengths minus one, with zero and oversize clamps
  always_comb begin
    kc = KCMP'(count_k);
    if (kc == '0) begin
      klen_m1 = '0;
    end else if (kc > KCMP'(MAX_K)) begin
      klen_m1 = KCMP'(MAX_K - 1);
    end else begin
      klen_m1 = kc - KCMP'(1);
    end
    bc = BCMP'(block_length);
    if (bc == '0) begin
      blen_m1 = '0;
    end else if (bc > BCMP'(MAX_BLOCK)) begin
      blen_m1 = BCMP'(MAX_BLOCK - 1);
    end else begin
      blen_m1 = bc - BCMP'(1);
    end
    ncol_m1 = (column_count == '0) ? '0 : column_count - COL_W'(1);
  end

  assign col_end = KCMP'(pos_col) >= klen_m1;
  assign blk_end = col_end || (BCMP'(pos_blk) >= blen_m1);
  assign last    = col_cnt >= ncol_m1;

  assign zp      = zero_point_mode ? zpcode : i4bqdp_pkg::IMPLICIT_ZP;
  assign diff    = $signed({1'b0, wcode}) - $signed({1'b0, zp});
  assign mac_sum = block_acc + BACC_W'(act * diff);

  assign bias_sum = bias_enable ? i4bqdp_pkg::sat_add64(col_acc, SUM_W'(bias)) : col_acc;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act    <= in_data[15:0];
      wcode  <= in_data[19:16];
      scale  <= in_data[35:20];
      zpcode <= in_data[39:36];
      bias   <= in_data[71:40];
    end
    if (cmd.step) begin
      blk_total <= mac_sum;
      col_idx   <= col_cnt;
      last_r    <= last;
    end
    if (cmd.mult) begin
      prod <= blk_total * scale;
    end
    // index and last flag are copied here so the next word cannot disturb a waiting result
    if (cmd.emit) begin
      out_sum    <= bias_sum;
      out_idx    <= col_idx;
      out_last_r <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_acc   <= '0;
      col_acc     <= '0;
      pos_col     <= '0;
      pos_blk     <= '0;
      col_cnt     <= '0;
      col_end_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.step) begin
        col_end_r <= col_end;
        block_acc <= blk_end ? '0 : mac_sum;
        pos_blk   <= blk_end ? '0 : pos_blk + BW'(1);
        pos_col   <= col_end ? '0 : pos_col + KW'(1);
        if (col_end) begin
          col_cnt <= last ? '0 : col_cnt + COL_W'(1);
        end
      end
      if (cmd.accum) begin
        col_acc <= i4bqdp_pkg::sat_add64(col_acc, SUM_W'(prod));
      end
      if (cmd.emit) begin
        col_acc     <= '0;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // block end is needed in the MAC state itself, before the counters move
  assign status.blk_end  = blk_end;
  assign status.col_end  = col_end_r;
  assign status.out_busy = out_valid_r && !out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = {out_idx, out_sum};
  assign out_last  = out_last_r;

endmodule

>>> sv/int4_block_quant_dot_product.sv
// Top level: block-quantized int4 weight dot product, one column result per count_k words.
// Each word is accepted and then takes a MAC step; a block end adds a scale multiply and a
// saturating accumulate, and a column end adds the bias add into the output register.
// One word is in flight at a time; a column end also stalls while the output register is full.
// A column's last word passes the MAC, scale, accumulate and emit states before its result is valid.
// Reset (rst, synchronous): accumulators, counters and output valid clear; registers take defaults.
module int4_block_quant_dot_product #(
  parameter int MAX_K     = i4bqdp_pkg::MAX_K_DEF,
  parameter int MAX_BLOCK = i4bqdp_pkg::MAX_BLOCK_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [i4bqdp_pkg::IDX_W-1:0]   cfg_index,
  input  logic [i4bqdp_pkg::CFG_W-1:0]   cfg_data,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // activation[15:0], weight_code[19:16], block_scale[35:20], zero_point_code[39:36],
  // column_bias[71:40]
  input  logic [i4bqdp_pkg::IN_W-1:0]    s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // column_sum[63:0], column_index[79:64]
  output logic [i4bqdp_pkg::OUT_W-1:0]   m_axis_tdata,
  output logic                           m_axis_tlast
);

  i4bqdp_pkg::dp_cmd_t    cmd;
  i4bqdp_pkg::dp_status_t status;

  i4bqdp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  i4bqdp_dp #(
    .MAX_K     (MAX_K),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

>>> sim/tb_int4_block_quant_dot_product.sv
// Self-checking testbench for the int4 block-quantized dot product: directed table, then random.
module tb_int4_block_quant_dot_product;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ACT_W   = i4bqdp_pkg::ACT_W;
  localparam int CODE_W  = i4bqdp_pkg::CODE_W;
  localparam int SCALE_W = i4bqdp_pkg::SCALE_W;
  localparam int BIAS_W  = i4bqdp_pkg::BIAS_W;
  localparam int SUM_W   = i4bqdp_pkg::SUM_W;
  localparam int COL_W   = i4bqdp_pkg::COL_W;
  localparam int BLEN_W  = i4bqdp_pkg::BLEN_W;
  localparam int KCNT_W  = i4bqdp_pkg::KCNT_W;
  localparam int CFG_W   = i4bqdp_pkg::CFG_W;
  localparam int IDX_W   = i4bqdp_pkg::IDX_W;
  localparam int IN_W    = i4bqdp_pkg::IN_W;
  localparam int OUT_W   = i4bqdp_pkg::OUT_W;

  localparam int SETTLE_CYCLES      = 16;
  localparam int RANDOM_PHASES      = 20;
  localparam int CLAMP_PHASE        = 12;
  localparam int CLAMP_WORDS        = 260;
  localparam int CALM_WORDS         = 60;
  localparam int HOLD_AFTER_RESULTS = 20;
  localparam int HOLD_CYCLES        = 400;

  localparam logic [IDX_W-1:0] REG_SPARE_FIRST = IDX_W'(i4bqdp_pkg::REG_BIAS_ENABLE + 1);
  localparam logic [IDX_W-1:0] REG_SPARE_LAST  = '1;

  // input word, first member in the top bits so it packs straight onto s_axis_tdata
  typedef struct packed {
    logic signed [BIAS_W-1:0]  bias;
    logic        [CODE_W-1:0]  zp;
    logic signed [SCALE_W-1:0] scale;
    logic        [CODE_W-1:0]  wc;
    logic signed [ACT_W-1:0]   act;
  } word_t;

  typedef struct packed {
    logic                    last;
    logic [COL_W-1:0]        index;
    logic signed [SUM_W-1:0] sum;
  } column_result_t;

  typedef enum bit {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [IDX_W-1:0] reg_sel;
    logic [CFG_W-1:0] reg_val;
    word_t            w;
    bit               typed;
    longint           typed_sum;
  } plan_row_t;

  // typed expectation travels with each word from driver to predictor
  typedef struct {
    bit     typed;
    longint sum;
  } typed_entry_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]  cfg_data;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              m_axis_tlast;

  int4_block_quant_dot_product DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // register copies, reset values
  int unsigned cur_block_len = 32;
  int unsigned cur_count_k   = 4096;
  int unsigned cur_col_count = 1;
  bit          cur_zp_mode   = 1'b0;
  bit          cur_bias_en   = 1'b0;

  // accumulation state
  longint      block_sum   = 0;
  longint      column_sum  = 0;
  int unsigned pos_column  = 0;
  int unsigned pos_block   = 0;
  int unsigned column_no   = 0;

  column_result_t expected_columns[$];
  typed_entry_t   typed_q[$];
  bit          sum_is_typed = 1'b0;
  longint      typed_sum;
  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  bit          calm         = 1'b0;
  plan_row_t   plan[$];

  function automatic longint clamp_add(input longint a, input longint b);
    longint s;
    s = a + b;
    if (a > 0 && b > 0 && s < 0) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (a < 0 && b < 0 && s >= 0) return -64'sh7FFF_FFFF_FFFF_FFFF - 1;
    return s;
  endfunction

  function automatic void accumulate_word(input word_t w);
    int unsigned    blen, klen, ncol;
    int             zp;
    bit             col_end, blk_end, last;
    longint         total;
    column_result_t r;
    typed_entry_t   e;
    e = typed_q.pop_front();
    blen = (cur_block_len == 0) ? 1 : cur_block_len;
    if (blen > i4bqdp_pkg::MAX_BLOCK_DEF) blen = i4bqdp_pkg::MAX_BLOCK_DEF;
    klen = (cur_count_k == 0) ? 1 : cur_count_k;
    if (klen > i4bqdp_pkg::MAX_K_DEF) klen = i4bqdp_pkg::MAX_K_DEF;
    ncol = (cur_col_count == 0) ? 1 : cur_col_count;
    zp = cur_zp_mode ? int'(w.zp) : int'(i4bqdp_pkg::IMPLICIT_ZP);
    block_sum = block_sum + longint'(w.act) * longint'(int'(w.wc) - zp);
    // a counter at or past a (possibly lowered) end closes on this word
    col_end = pos_column >= klen - 1;
    blk_end = col_end || pos_block >= blen - 1;
    if (blk_end) begin
      column_sum = clamp_add(column_sum, block_sum * longint'(w.scale));
      block_sum = 0;
      pos_block = 0;
    end else begin
      pos_block++;
    end
    if (!col_end) begin
      pos_column++;
      return;
    end
    total = column_sum;
    if (cur_bias_en) total = clamp_add(total, longint'(w.bias));
    last = column_no >= ncol - 1;
    r.sum = e.typed ? e.sum : total;
    r.index = column_no[COL_W-1:0];
    r.last = last;
    expected_columns.push_back(r);
    column_sum = 0;
    pos_column = 0;
    column_no = last ? 0 : column_no + 1;
  endfunction

  function automatic word_t make_word(input longint act, input int wc, input longint scale,
                                      input int zp, input longint bias);
    word_t w;
    w.act   = act[ACT_W-1:0];
    w.wc    = wc[CODE_W-1:0];
    w.scale = scale[SCALE_W-1:0];
    w.zp    = zp[CODE_W-1:0];
    w.bias  = bias[BIAS_W-1:0];
    return w;
  endfunction

  // extremes show up often, the rest is uniform
  function automatic longint biased_value(input int bits);
    longint lo, v;
    lo = -(longint'(1) << (bits - 1));
    case ($urandom_range(0, 7))
      0: v = lo;
      1: v = -lo - 1;
      2: v = 0;
      3: v = -1;
      default: begin
        v = longint'($urandom) & ((longint'(1) << bits) - 1);
        if (v >= -lo) v = v + 2 * lo;
      end
    endcase
    return v;
  endfunction

  function automatic word_t rand_word();
    return make_word(biased_value(ACT_W), $urandom_range(0, 15), biased_value(SCALE_W),
                     $urandom_range(0, 15), biased_value(BIAS_W));
  endfunction

  function automatic void add_cfg(input logic [IDX_W-1:0] sel, input logic [CFG_W-1:0] val);
    plan_row_t row;
    row.kind = ROW_CFG;
    row.reg_sel = sel;
    row.reg_val = val;
    row.w = '0;
    row.typed = 1'b0;
    row.typed_sum = 0;
    plan.push_back(row);
  endfunction

  function automatic void add_word(input longint act, input int wc, input longint scale,
                                   input int zp, input longint bias, input bit typed,
                                   input longint want);
    plan_row_t row;
    row.kind = ROW_WORD;
    row.reg_sel = '0;
    row.reg_val = '0;
    row.w = make_word(act, wc, scale, zp, bias);
    row.typed = typed;
    row.typed_sum = want;
    plan.push_back(row);
  endfunction

  task automatic write_reg(input logic [IDX_W-1:0] sel, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    case (sel)
      i4bqdp_pkg::REG_BLOCK_LENGTH: cur_block_len = val[BLEN_W-1:0];
      i4bqdp_pkg::REG_COUNT_K:      cur_count_k   = val[KCNT_W-1:0];
      i4bqdp_pkg::REG_COLUMN_COUNT: cur_col_count = val[COL_W-1:0];
      i4bqdp_pkg::REG_ZP_MODE:      cur_zp_mode   = val[0];
      i4bqdp_pkg::REG_BIAS_ENABLE:  cur_bias_en   = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_word(input word_t w, input bit quiet);
    int unsigned  gap;
    typed_entry_t e;
    e.typed = sum_is_typed;
    e.sum   = typed_sum;
    typed_q.push_back(e);
    if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= w;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // idle point: nothing pending, and a word with no result has had time to finish
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_columns.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) accumulate_word(word_t'(s_axis_tdata));
  end

  always @(posedge clk) begin : check_columns
    column_result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.sum   = m_axis_tdata[SUM_W-1:0];
      got.index = m_axis_tdata[SUM_W +: COL_W];
      got.last  = m_axis_tlast;
      results_seen++;
      if (expected_columns.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result sum %0d index %0d last %0d",
                 $time, got.sum, got.index, got.last);
      end else begin
        want = expected_columns.pop_front();
        if (got.sum !== want.sum) begin
          mismatches++;
          $display("%0t: column_sum expected %0d got %0d", $time, want.sum, got.sum);
        end
        if (got.index !== want.index) begin
          mismatches++;
          $display("%0t: column_index expected %0d got %0d", $time, want.index, got.index);
        end
        if (got.last !== want.last) begin
          mismatches++;
          $display("%0t: last_column expected %0d got %0d", $time, want.last, got.last);
        end
      end
    end
  end

  // output side: random stalls plus one long hold while words keep coming
  initial begin : drain_side
    int unsigned hold_left, gap_left;
    bit          hold_armed, stall;
    hold_left = 0;
    gap_left = 0;
    hold_armed = 1'b1;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        stall = 1'b1;
      end else if (hold_armed && results_seen >= HOLD_AFTER_RESULTS && s_axis_tvalid) begin
        hold_armed = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        stall = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        stall = 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(0, 12);
        stall = 1'b1;
      end else begin
        stall = 1'b0;
      end
      m_axis_tready <= !stall;
    end
  end

  initial begin : stimulus
    int unsigned      n_words, phase;
    int               k;
    bit               quiet;
    logic [CFG_W-1:0] val;
    plan_row_t        row;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: one full block of 32 and 8 more words, then count_k lowered to one
    // closes the column on a ninth; 41 words of 1 * (15 - 8)
    sum_is_typed = 1'b1;
    typed_sum = 287;
    repeat (40) send_word(make_word(1, 15, 1, 0, 0), 1'b0);
    wait_drained();
    write_reg(i4bqdp_pkg::REG_COUNT_K, CFG_W'(1));
    send_word(make_word(1, 15, 1, 0, 0), 1'b0);
    wait_drained();
    sum_is_typed = 1'b0;

    add_cfg(i4bqdp_pkg::REG_COUNT_K, CFG_W'(1));
    add_cfg(i4bqdp_pkg::REG_COLUMN_COUNT, CFG_W'(0));
    add_cfg(i4bqdp_pkg::REG_BIAS_ENABLE, CFG_W'(1));
    // implicit zero point, the zero point field is ignored
    add_word(32767, 15, 32767, 0, 0, 1'b1, 64'sd7515734023);
    add_word(-32768, 0, -32768, 15, 0, 1'b1, -64'sd8589934592);
    add_word(-32768, 15, 32767, 0, 0, 1'b1, -64'sd7515963392);
    add_word(0, 15, -32768, 0, 64'sd2147483647, 1'b1, 64'sd2147483647);
    add_word(0, 0, 32767, 0, -64'sd2147483648, 1'b1, -64'sd2147483648);
    add_word(1, 8, 1, 3, 0, 1'b1, 0);
    add_cfg(i4bqdp_pkg::REG_ZP_MODE, CFG_W'(1));
    add_word(1, 0, 1, 15, 0, 1'b1, -15);
    add_word(-32768, 15, -32768, 0, -64'sd2147483648, 1'b1, 64'sd13958643712);
    add_word(32767, 0, 32767, 15, 64'sd2147483647, 1'b1, -64'sd13957660688);
    add_word(100, 5, 1, 5, 0, 1'b1, 0);
    add_cfg(i4bqdp_pkg::REG_BIAS_ENABLE, CFG_W'(0));
    add_word(1, 9, 3, 8, 12345, 1'b1, 3);
    // zero block length acts as one
    add_cfg(i4bqdp_pkg::REG_COUNT_K, CFG_W'(2));
    add_cfg(i4bqdp_pkg::REG_BLOCK_LENGTH, CFG_W'(0));
    add_word(-32768, 15, 32767, 4, 0, 1'b0, 0);
    add_word(32767, 0, -32768, 11, 0, 1'b0, 0);
    // odd block length, short last block
    add_cfg(i4bqdp_pkg::REG_BLOCK_LENGTH, CFG_W'(3));
    add_cfg(i4bqdp_pkg::REG_COUNT_K, CFG_W'(7));
    add_cfg(i4bqdp_pkg::REG_COLUMN_COUNT, CFG_W'(2));
    for (k = 0; k < 7; k++) add_word(longint'(k) * 9000 - 30000, k * 2, 1000 - k * 700, k, 0,
                                     1'b0, 0);
    // three words open a column of six, then count_k lowered below the position: the next word closes it
    add_cfg(i4bqdp_pkg::REG_COUNT_K, CFG_W'(6));
    for (k = 0; k < 3; k++) add_word(-1000 * k, 15 - k, 7, k + 4, 0, 1'b0, 0);
    add_cfg(i4bqdp_pkg::REG_COUNT_K, CFG_W'(2));
    add_word(12345, 3, -2, 9, 0, 1'b0, 0);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_CFG) begin
        wait_drained();
        write_reg(row.reg_sel, row.reg_val);
      end else begin
        sum_is_typed = row.typed;
        typed_sum = row.typed_sum;
        send_word(row.w, 1'b0);
      end
    end
    wait_drained();
    sum_is_typed = 1'b0;

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      quiet = $urandom_range(0, 3) == 0;
      if (phase == CLAMP_PHASE) begin
        // close any open column first so the long one starts clean
        write_reg(i4bqdp_pkg::REG_COUNT_K, CFG_W'(1));
        send_word(rand_word(), quiet);
        wait_drained();
        write_reg(i4bqdp_pkg::REG_BLOCK_LENGTH, 16'h01FF);
        write_reg(i4bqdp_pkg::REG_COUNT_K, 16'h7FFF);
        write_reg(i4bqdp_pkg::REG_COLUMN_COUNT, 16'hFFFF);
        write_reg(i4bqdp_pkg::REG_ZP_MODE, CFG_W'($urandom));
        write_reg(i4bqdp_pkg::REG_BIAS_ENABLE, CFG_W'(1));
        // crosses the first clamped block end; a later phase closes the column
        n_words = CLAMP_WORDS;
      end else begin
        case ($urandom_range(0, 5))
          0: val = '0;
          1: val = CFG_W'(16);
          2: val = CFG_W'(i4bqdp_pkg::MAX_BLOCK_DEF);
          3: val = 16'h01FF;
          4: val = CFG_W'(16 << $urandom_range(0, 4));
          default: val = CFG_W'($urandom_range(1, 300));
        endcase
        val[CFG_W-1:BLEN_W] = (CFG_W-BLEN_W)'($urandom);
        write_reg(i4bqdp_pkg::REG_BLOCK_LENGTH, val);
        case ($urandom_range(0, 7))
          0: val = '0;
          1: val = CFG_W'(1);
          2: val = CFG_W'($urandom_range(100, 400));
          default: val = CFG_W'($urandom_range(2, 40));
        endcase
        val[CFG_W-1] = 1'($urandom_range(0, 1));
        write_reg(i4bqdp_pkg::REG_COUNT_K, val);
        case ($urandom_range(0, 5))
          0: val = '0;
          1: val = CFG_W'(1);
          2: val = 16'hFFFF;
          default: val = CFG_W'($urandom_range(2, 6));
        endcase
        write_reg(i4bqdp_pkg::REG_COLUMN_COUNT, val);
        write_reg(i4bqdp_pkg::REG_ZP_MODE, CFG_W'($urandom));
        write_reg(i4bqdp_pkg::REG_BIAS_ENABLE, CFG_W'($urandom));
        if ($urandom_range(0, 2) == 0)
          write_reg(IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), CFG_W'($urandom));
        n_words = $urandom_range(1, 24);
      end
      repeat (n_words) send_word(rand_word(), quiet);
      wait_drained();
    end

    calm = 1'b1;
    write_reg(i4bqdp_pkg::REG_COUNT_K, CFG_W'(3));
    repeat (CALM_WORDS) send_word(rand_word(), 1'b0);
    wait_drained();

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
